// ===== rtl/core/gbn_pkg.sv =====
// Go-Back-N sender window: shared types and constants.
// No dependencies; imported by every module of the block except gbn_ram.
package gbn_pkg;

    localparam int SEQ_SPACE      = 16;
    localparam int SEQ_W          = 4;
    localparam int HANDLE_W       = 16;
    localparam int WIN_W          = 4;
    localparam logic [WIN_W-1:0] DEFAULT_WINDOW = WIN_W'(4);

    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_TIMEOUT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        TMR_NONE  = 2'd0,
        TMR_START = 2'd1,
        TMR_STOP  = 2'd2
    } timer_cmd_t;

    typedef struct packed {
        action_t             action;
        logic [HANDLE_W-1:0] msg_handle;
        logic [SEQ_W-1:0]    ack_seq;
        logic                ack_check_ok;
    } cmd_t;

    typedef struct packed {
        logic                tx_valid;
        logic [SEQ_W-1:0]    tx_seq;
        logic [HANDLE_W-1:0] tx_handle;
        timer_cmd_t          timer_cmd;
        logic                accepted;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic                we;
        logic [SEQ_W-1:0]    waddr;
        logic [HANDLE_W-1:0] wdata;
        logic                re;
        logic [SEQ_W-1:0]    raddr;
    } ram_req_t;

endpackage

// ===== rtl/core/gbn_ram.sv =====
// Generic single-clock RAM, one write and one registered read port.
// No dependencies.
module gbn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem[raddr];
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/core/gbn_ctrl.sv =====
// Go-Back-N window control: base/next pointers, send/ack decisions, resend walk.
// Depends on gbn_pkg; drives the handle RAM through a ram_req_t.
module gbn_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [gbn_pkg::WIN_W-1:0]    window_size,
    input  logic                         start,
    output logic                         busy,
    input  gbn_pkg::cmd_t                cmd,
    output gbn_pkg::ram_req_t            ram_req,
    input  logic [gbn_pkg::HANDLE_W-1:0] ram_q,
    output logic                         rsp_valid,
    output gbn_pkg::rsp_t                rsp
);

    import gbn_pkg::*;

    logic [SEQ_W-1:0]    base_reg, base_next;
    logic [SEQ_W-1:0]    next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]    cnt_reg, cnt_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                tx_valid_reg, tx_valid_next;
    logic [SEQ_W-1:0]    tx_seq_reg, tx_seq_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic                from_ram_reg, from_ram_next;
    timer_cmd_t          timer_reg, timer_next;
    logic                acc_reg, acc_next;
    logic                last_reg, last_next;

    logic                accept;
    logic [WIN_W-1:0]    eff_win;
    logic [SEQ_W-1:0]    outst;
    logic [SEQ_W-1:0]    ack_dist;
    logic [SEQ_W-1:0]    ack_plus1;
    logic [SEQ_W-1:0]    walk_seq;

    assign busy      = (cnt_reg != '0);
    assign accept    = start && !busy;
    assign eff_win   = (window_size == '0) ? DEFAULT_WINDOW : window_size;
    assign outst     = next_seq_reg - base_reg;
    assign ack_dist  = cmd.ack_seq - base_reg;
    assign ack_plus1 = cmd.ack_seq + SEQ_W'(1);
    assign walk_seq  = tx_seq_reg + SEQ_W'(1);

    always_comb
    begin
        base_next      = base_reg;
        next_seq_next  = next_seq_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = 1'b0;
        tx_valid_next  = 1'b0;
        tx_seq_next    = '0;
        handle_next    = '0;
        from_ram_next  = 1'b0;
        timer_next     = TMR_NONE;
        acc_next       = 1'b0;
        last_next      = 1'b1;
        ram_req        = '0;

        if (accept)
        begin
            rsp_valid_next = 1'b1;
            unique case (cmd.action)
                ACT_SEND:
                begin
                    if (outst < eff_win)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = next_seq_reg;
                        ram_req.wdata = cmd.msg_handle;
                        next_seq_next = next_seq_reg + SEQ_W'(1);
                        tx_valid_next = 1'b1;
                        tx_seq_next   = next_seq_reg;
                        handle_next   = cmd.msg_handle;
                        timer_next    = (outst == '0) ? TMR_START : TMR_NONE;
                        acc_next      = 1'b1;
                    end
                end
                ACT_ACK:
                begin
                    if (cmd.ack_check_ok && (ack_dist < outst))
                    begin
                        base_next  = ack_plus1;
                        timer_next = (ack_plus1 == next_seq_reg) ? TMR_STOP : TMR_NONE;
                    end
                end
                ACT_TIMEOUT:
                begin
                    timer_next = TMR_START;
                    if (outst != '0)
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = base_reg;
                        tx_valid_next = 1'b1;
                        tx_seq_next   = base_reg;
                        from_ram_next = 1'b1;
                        last_next     = (outst == SEQ_W'(1));
                        cnt_next      = outst - SEQ_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (busy)
        begin
            // resend walk: one stored handle per cycle
            rsp_valid_next = 1'b1;
            ram_req.re     = 1'b1;
            ram_req.raddr  = walk_seq;
            tx_valid_next  = 1'b1;
            tx_seq_next    = walk_seq;
            from_ram_next  = 1'b1;
            last_next      = (cnt_reg == SEQ_W'(1));
            cnt_next       = cnt_reg - SEQ_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            next_seq_reg  <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            next_seq_reg  <= next_seq_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_valid_reg <= tx_valid_next;
        tx_seq_reg   <= tx_seq_next;
        handle_reg   <= handle_next;
        from_ram_reg <= from_ram_next;
        timer_reg    <= timer_next;
        acc_reg      <= acc_next;
        last_reg     <= last_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign rsp.tx_valid  = tx_valid_reg;
    assign rsp.tx_seq    = tx_seq_reg;
    assign rsp.tx_handle = from_ram_reg ? ram_q : handle_reg;
    assign rsp.timer_cmd = timer_reg;
    assign rsp.accepted  = acc_reg;
    assign rsp.last      = last_reg;

endmodule

// ===== rtl/core/go_back_n_sender_window_top.sv =====
// Go-Back-N ARQ sender window, top level: window size register, control, handle RAM.
// Depends on gbn_pkg, gbn_ram and gbn_ctrl.
//
//  channel  | signals                   | handshake
//  ---------+---------------------------+-----------------------------------
//  command  | start, busy, cmd          | taken when start && !busy
//  result   | rsp_valid, rsp            | one cycle per item, no back-pressure
//  config   | cfg_valid, cfg_ready, data| written when cfg_valid && cfg_ready
//
// Send, ack, unused codes and a timeout with nothing outstanding: one result the cycle
// after the command; busy stays low. Timeout with n > 0 packets outstanding: n results
// on consecutive cycles, read one per cycle from the handle RAM; busy is high while the
// walk reads the RAM, so the next command is taken in the cycle that shows the last result.
// Reset clears the window pointers and sets the window size to 4; the RAM is not cleared.
module go_back_n_sender_window_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  gbn_pkg::cmd_t             cmd,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [gbn_pkg::WIN_W-1:0] cfg_data,
    output logic                      rsp_valid,
    output gbn_pkg::rsp_t             rsp
);

    import gbn_pkg::*;

    logic [WIN_W-1:0]    window_reg;
    ram_req_t            ram_req;
    logic [HANDLE_W-1:0] ram_q;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= DEFAULT_WINDOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            window_reg <= cfg_data;
        end
    end

    gbn_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .window_size (window_reg),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .ram_req     (ram_req),
        .ram_q       (ram_q),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp)
    );

    gbn_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (SEQ_SPACE)
    ) u_handle_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .q     (ram_q)
    );

endmodule

// ===== rtl/core/gbn_chk.sv =====
// Port-level checks for the Go-Back-N sender window, bound to the top level.
// Depends on gbn_pkg and go_back_n_sender_window_top.
module gbn_chk (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      rsp_valid,
    input  gbn_pkg::rsp_t             rsp
);

    import gbn_pkg::*;

    // every item gives a result the next cycle
    a_item_answered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> rsp_valid)
        else $error("accepted item gave no result");

    // no result appears without an item or a walk behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ($past(start && !busy) || $past(busy)))
        else $error("result without cause");

    // busy only during a resend walk, which shows a result every cycle
    a_busy_walk: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (rsp_valid && rsp.tx_valid && !rsp.last))
        else $error("busy without resend in progress");

    // the last result frees the command port
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.last) |-> !busy)
        else $error("busy after last result");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.tx_valid) |-> (rsp.tx_seq == '0 && rsp.tx_handle == '0))
        else $error("non-transmit result carries packet fields");

endmodule

bind go_back_n_sender_window_top gbn_chk u_gbn_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
);

// ===== test/gbn_sender_checker.sv =====
// Checker for the Go-Back-N sender window: tracks the window and handle store, predicts
// every result item from the accepted commands and compares it with what the block sends.
// Depends on gbn_pkg; instantiated beside u_top by go_back_n_sender_window_top_test.
module gbn_sender_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  gbn_pkg::cmd_t             cmd,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [gbn_pkg::WIN_W-1:0] cfg_data,
    input  logic                      rsp_valid,
    input  gbn_pkg::rsp_t             rsp,
    output int                        mismatches,
    output int                        rsp_due,
    output logic [gbn_pkg::SEQ_W-1:0] base_seq,
    output logic [gbn_pkg::SEQ_W-1:0] next_seq
);
    timeunit 1ns;
    timeprecision 1ps;

    import gbn_pkg::*;

    logic [WIN_W-1:0]    win_reg;
    logic [HANDLE_W-1:0] handles [SEQ_SPACE];
    rsp_t                due_q [$];

    task automatic advance_window(input cmd_t c);
        logic [SEQ_W-1:0] inflight;
        logic [SEQ_W-1:0] ack_gap;
        logic [SEQ_W-1:0] s;
        logic [WIN_W-1:0] room;
        rsp_t             r;
        inflight = next_seq - base_seq;
        room     = (win_reg == '0) ? DEFAULT_WINDOW : win_reg;
        r        = '0;
        r.last   = 1'b1;
        case (c.action)
            ACT_SEND:
            begin
                if (inflight < room)
                begin
                    r.tx_valid  = 1'b1;
                    r.tx_seq    = next_seq;
                    r.tx_handle = c.msg_handle;
                    r.accepted  = 1'b1;
                    if (inflight == '0)
                        r.timer_cmd = TMR_START;
                    handles[next_seq] = c.msg_handle;
                    next_seq = next_seq + 1'b1;
                end
                due_q.push_back(r);
            end
            ACT_ACK:
            begin
                ack_gap = c.ack_seq - base_seq;
                if (c.ack_check_ok && ack_gap < inflight)
                begin
                    base_seq = c.ack_seq + 1'b1;
                    if (base_seq == next_seq)
                        r.timer_cmd = TMR_STOP;
                end
                due_q.push_back(r);
            end
            ACT_TIMEOUT:
            begin
                if (inflight == '0)
                begin
                    r.timer_cmd = TMR_START;
                    due_q.push_back(r);
                end
                for (int i = 0; i < int'(inflight); i++)
                begin
                    s           = base_seq + SEQ_W'(i);
                    r           = '0;
                    r.tx_valid  = 1'b1;
                    r.tx_seq    = s;
                    r.tx_handle = handles[s];
                    if (i == 0)
                        r.timer_cmd = TMR_START;
                    r.last      = (i == int'(inflight) - 1);
                    due_q.push_back(r);
                end
            end
            default:
                due_q.push_back(r);
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            win_reg    = DEFAULT_WINDOW;
            base_seq   = '0;
            next_seq   = '0;
            due_q.delete();
            rsp_due    = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                win_reg = cfg_data;
            if (rsp_valid)
            begin
                if (due_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: result item with none due", $realtime);
                end
                else
                begin
                    want = due_q.pop_front();
                    if (rsp.tx_valid !== want.tx_valid || rsp.tx_seq !== want.tx_seq ||
                        rsp.tx_handle !== want.tx_handle || rsp.timer_cmd !== want.timer_cmd ||
                        rsp.accepted !== want.accepted || rsp.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at %0t: expected valid=%0b seq=%0d handle=%h ",
                                     $realtime, want.tx_valid, want.tx_seq, want.tx_handle,
                                     "timer=%0d acc=%0b last=%0b, ",
                                     want.timer_cmd, want.accepted, want.last,
                                     "got valid=%0b seq=%0d handle=%h ",
                                     rsp.tx_valid, rsp.tx_seq, rsp.tx_handle,
                                     "timer=%0d acc=%0b last=%0b",
                                     rsp.timer_cmd, rsp.accepted, rsp.last);
                    end
                end
            end
            if (start && !busy)
                advance_window(cmd);
            rsp_due = due_q.size();
        end
    end

endmodule

// ===== test/go_back_n_sender_window_top_test.sv =====
// Top of the Go-Back-N sender window test: clock, reset, window size writes and command
// items, directed then random; verdict from the failure count of gbn_sender_checker.
// Depends on gbn_pkg, go_back_n_sender_window_top and gbn_sender_checker.
module go_back_n_sender_window_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gbn_pkg::*;

    localparam action_t ACT_UNUSED = action_t'(2'd3);

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cmd_t             cmd;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [WIN_W-1:0] cfg_data;
    logic             rsp_valid;
    rsp_t             rsp;
    int               mismatches;
    int               rsp_due;
    logic [SEQ_W-1:0] base_seq;
    logic [SEQ_W-1:0] next_seq;

    go_back_n_sender_window_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    gbn_sender_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp),
        .mismatches (mismatches),
        .rsp_due    (rsp_due),
        .base_seq   (base_seq),
        .next_seq   (next_seq)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic cmd_t mk(input action_t a, input logic [HANDLE_W-1:0] h,
                                input logic [SEQ_W-1:0] s, input logic ok);
        cmd_t c;
        c.action       = a;
        c.msg_handle   = h;
        c.ack_seq      = s;
        c.ack_check_ok = ok;
        return c;
    endfunction

    // mostly sends and acks (acks mostly of outstanding packets with a good checksum), some noise
    function automatic cmd_t rand_item();
        cmd_t             c;
        logic [SEQ_W-1:0] inflight;
        int               pick;
        c        = mk(ACT_SEND, HANDLE_W'($urandom), SEQ_W'($urandom), 1'($urandom));
        inflight = next_seq - base_seq;
        pick     = $urandom_range(0, 99);
        if (pick < 45)
            c.action = ACT_SEND;
        else if (pick < 80)
        begin
            c.action = ACT_ACK;
            if (inflight != '0 && $urandom_range(0, 9) < 8)
            begin
                c.ack_seq      = base_seq + SEQ_W'($urandom_range(0, int'(inflight) - 1));
                c.ack_check_ok = ($urandom_range(0, 9) != 0);
            end
        end
        else if (pick < 97)
            c.action = ACT_TIMEOUT;
        else
            c.action = ACT_UNUSED;
        return c;
    endfunction

    task automatic issue(input cmd_t c, input bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (rsp_due != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] w);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #200us;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        logic [WIN_W-1:0] w;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset window of 4
        issue(mk(ACT_TIMEOUT, 16'h0000, 4'h0, 1'b0), 1'b1);
        issue(mk(ACT_ACK, 16'hffff, 4'h0, 1'b1), 1'b1);
        issue(mk(ACT_SEND, 16'h0000, 4'hf, 1'b1), 1'b1);
        issue(mk(ACT_SEND, 16'hffff, 4'h0, 1'b0), 1'b1);
        issue(mk(ACT_SEND, 16'ha5a5, 4'h0, 1'b0), 1'b1);
        issue(mk(ACT_SEND, 16'h5a5a, 4'h0, 1'b0), 1'b1);
        issue(mk(ACT_SEND, 16'h1234, 4'h0, 1'b0), 1'b1);
        issue(mk(ACT_TIMEOUT, 16'hffff, 4'hf, 1'b1), 1'b1);
        issue(mk(ACT_ACK, 16'h0000, 4'h1, 1'b0), 1'b1);
        issue(mk(ACT_ACK, 16'h0000, 4'hf, 1'b1), 1'b1);
        issue(mk(ACT_ACK, 16'h0000, 4'h1, 1'b1), 1'b1);
        issue(mk(ACT_ACK, 16'h0000, 4'h3, 1'b1), 1'b1);
        issue(mk(ACT_UNUSED, 16'hffff, 4'hf, 1'b1), 1'b1);

        // widest window: fill, refuse, resend all, clear
        set_window(4'd15);
        repeat (16)
            issue(mk(ACT_SEND, HANDLE_W'($urandom), 4'h0, 1'b0), 1'b1);
        issue(mk(ACT_TIMEOUT, 16'h0000, 4'h0, 1'b0), 1'b1);
        issue(mk(ACT_ACK, 16'h0000, next_seq - 1'b1, 1'b1), 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: w = 4'd1;
                1: w = 4'd0;
                2: w = 4'd15;
                5: w = WIN_W'($urandom_range(0, 15));
                default: w = WIN_W'($urandom_range(1, 15));
            endcase
            set_window(w);
            repeat (50)
            begin
                if ($urandom_range(0, 39) == 0)
                    settle();
                issue(rand_item(), p != 5);
            end
        end

        settle();
        if (mismatches == 0 && rsp_due == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gbn_pkg.sv
rtl/core/gbn_ram.sv
rtl/core/gbn_ctrl.sv
rtl/core/go_back_n_sender_window_top.sv
rtl/core/gbn_chk.sv
test/gbn_sender_checker.sv
test/go_back_n_sender_window_top_test.sv
